// ===== hw/rtl/bipartite_label_propagation_macros.svh =====
// Assertion macros for the label propagation block.
// No dependencies; included by modules that assert.
`ifndef BIPARTITE_LABEL_PROPAGATION_MACROS_SVH
`define BIPARTITE_LABEL_PROPAGATION_MACROS_SVH
`ifndef ASSERT_OFF
`define BLP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m");
`define BLP_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("%m");
`else
`define BLP_ASSERT(label, clk, rst_n, prop)
`define BLP_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== hw/rtl/blp_pkg.sv =====
// Package for the label propagation block: sizes, action codes, states.
// No dependencies.
package blp_pkg;
    localparam int FEATURE_NODES   = 4096;
    localparam int UNLABELED_NODES = 4096;
    localparam int MAX_CLASSES     = 2;
    localparam int CLS_W  = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int FADR_W = $clog2(FEATURE_NODES * MAX_CLASSES);
    localparam int UADR_W = $clog2(UNLABELED_NODES * MAX_CLASSES);
    localparam logic [16:0] ONE_Q16 = 17'd65536;

    typedef enum logic [2:0] {
        ACT_LABELED  = 3'd0,
        ACT_F2U      = 3'd1,
        ACT_U2F      = 3'd2,
        ACT_NORM_F   = 3'd3,
        ACT_NORM_U   = 3'd4,
        ACT_DECAY    = 3'd5,
        ACT_INIT     = 3'd6,
        ACT_READ     = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        CFG_CLASS_COUNT = 2'd0,
        CFG_DISCOUNT    = 2'd1
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,      // issue reads for class cls_reg
        ST_RDW,     // read data arrives
        ST_MUL1,    // alpha * score
        ST_MUL2,    // * weight, accumulate, write
        ST_DIVS,    // start divide for class
        ST_DIVW,    // wait divide, write result
        ST_INIT,
        ST_DECAY
    } state_t;

    typedef struct packed {
        logic        start;
        logic [47:0] dividend;
        logic [35:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [47:0] b);
        logic [48:0] s;
        s = {17'd0, a} + {1'b0, b};
        sat_add = (s[48:32] != 17'd0) ? 32'hFFFF_FFFF : s[31:0];
    endfunction
endpackage

// ===== hw/rtl/blp_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module blp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== hw/rtl/blp_div.sv =====
// Restoring divider, one quotient bit per cycle, 48 by 36 bits to 32 bits.
// Depends on blp_pkg.
module blp_div (
    input  logic              clk,
    input  logic              rst_n,
    input  blp_pkg::div_req_t req,
    output blp_pkg::div_rsp_t rsp
);
    logic [47:0] rem_reg, rem_next;
    logic [47:0] quo_reg, quo_next;
    logic [35:0] den_reg, den_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [48:0] trial;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[47]} - {13'd0, den_reg};
        if (req.start)
        begin
            rem_next = 48'd0;
            quo_next = req.dividend;
            den_next = req.divisor;
            cnt_next = 6'd48;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            // shift in next dividend bit, subtract where it fits
            if (!trial[48])
            begin
                rem_next = trial[47:0];
                quo_next = {quo_reg[46:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[46:0], quo_reg[47]};
                quo_next = {quo_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg[31:0];
endmodule

// ===== hw/rtl/bipartite_label_propagation.sv =====
// Bipartite label propagation engine: one job per start beat.
// Steps: an edge runs RD, RDW, MUL1, MUL2 per class (a labeled edge, its class
// only); normalize folds each class (RD, RDW), then divides each (RD, RDW, DIVS,
// DIVW: start, divider steps, write-back); init writes each class; decay
// updates alpha; read gives one result beat per class, each after RD, RDW.
// Throughput: one item at a time, busy until it ends; memory port and divider set the rate.
// Reset: alpha 1.0, class_count 2, discount 0.5; tables undefined until init.
// Results cannot be stalled: done strobes for one cycle per result beat.
`include "bipartite_label_propagation_macros.svh"
module bipartite_label_propagation (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  action,
    input  logic [11:0] feature_index,
    input  logic [11:0] data_index,
    input  logic [2:0]  class_label,
    input  logic [31:0] weight,
    output logic        done,
    output logic [11:0] node_index,
    output logic [2:0]  class_index,
    output logic [31:0] probability,
    output logic        last
);
    localparam int CW = blp_pkg::CLS_W;
    localparam int FW = blp_pkg::FADR_W;
    localparam int UW = blp_pkg::UADR_W;

    // initial score 1/n for class counts that are not a power of two
    localparam logic [16:0] INIT_Q3 = 17'(32'd65536 / 32'd3);
    localparam logic [16:0] INIT_Q5 = 17'(32'd65536 / 32'd5);
    localparam logic [16:0] INIT_Q6 = 17'(32'd65536 / 32'd6);
    localparam logic [16:0] INIT_Q7 = 17'(32'd65536 / 32'd7);

    // configuration and alpha
    logic [3:0]  class_count_reg;
    logic [16:0] discount_reg;
    logic [16:0] alpha_reg, alpha_next;
    logic [3:0]  n_use;

    always_comb
    begin
        n_use = class_count_reg;
        if (n_use < 4'd1)
        begin
            n_use = 4'd1;
        end
        if (n_use > 4'(blp_pkg::MAX_CLASSES))
        begin
            n_use = 4'(blp_pkg::MAX_CLASSES);
        end
    end

    // held item
    blp_pkg::action_t  act_reg;
    logic [11:0]       f_reg, d_reg;
    logic [2:0]        lbl_reg;
    logic [31:0]       w_reg;
    logic [CW-1:0]     cls_reg, cls_next;
    logic              pass_reg, pass_next;    // normalize: 0 fold, 1 divide
    logic [35:0]       total_reg, total_next;

    blp_pkg::state_t   state_reg, state_next;

    // memories: fc, fa, uc, ua
    logic          fc_we, fa_we, uc_we, ua_we;
    logic [31:0]   fc_wd, fa_wd, uc_wd, ua_wd;
    logic [31:0]   fc_rd, fa_rd, uc_rd, ua_rd;
    logic [FW-1:0] f_addr;
    logic [UW-1:0] u_addr;

    logic [31:0] cur_reg, cur_next;     // captured score
    logic [31:0] acc_reg, acc_next;     // captured accumulator
    logic [47:0] prod_reg, prod_next;

    blp_pkg::div_req_t div_req;
    blp_pkg::div_rsp_t div_rsp;

    logic f_ok, d_ok;
    logic done_next, last_next;
    logic [31:0] prob_next;
    logic [CW-1:0] cls_out_next;
    logic [CW-1:0] cls_out_reg;
    logic [CW:0]   cls_ext;
    logic is_f_side;
    logic [31:0] div_cur;
    logic [16:0] init_val;

    assign f_ok = {4'd0, f_reg} < 16'(blp_pkg::FEATURE_NODES);
    assign d_ok = {4'd0, d_reg} < 16'(blp_pkg::UNLABELED_NODES);
    assign cls_ext = {1'b0, cls_reg} + {{CW{1'b0}}, 1'b1};

    // labeled edge targets its class, others walk cls_reg
    logic [CW-1:0] addr_cls;
    assign addr_cls = (act_reg == blp_pkg::ACT_LABELED) ? lbl_reg[CW-1:0] : cls_reg;
    assign f_addr = FW'({f_reg, addr_cls});
    assign u_addr = UW'({d_reg, cls_reg});

    assign is_f_side = (act_reg == blp_pkg::ACT_NORM_F);
    assign div_cur   = is_f_side ? fc_rd : uc_rd;

    always_comb
    begin
        case (n_use)
            4'd1:    init_val = blp_pkg::ONE_Q16;
            4'd2:    init_val = blp_pkg::ONE_Q16 >> 1;
            4'd3:    init_val = INIT_Q3;
            4'd4:    init_val = blp_pkg::ONE_Q16 >> 2;
            4'd5:    init_val = INIT_Q5;
            4'd6:    init_val = INIT_Q6;
            4'd7:    init_val = INIT_Q7;
            default: init_val = blp_pkg::ONE_Q16 >> 3;
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        cls_next     = cls_reg;
        pass_next    = pass_reg;
        total_next   = total_reg;
        alpha_next   = alpha_reg;
        cur_next     = cur_reg;
        acc_next     = acc_reg;
        prod_next    = prod_reg;
        fc_we = 1'b0; fa_we = 1'b0; uc_we = 1'b0; ua_we = 1'b0;
        fc_wd = 32'd0; fa_wd = 32'd0; uc_wd = 32'd0; ua_wd = 32'd0;
        div_req      = '0;
        done_next    = 1'b0;
        last_next    = 1'b0;
        prob_next    = 32'd0;
        cls_out_next = cls_reg;
        case (state_reg)
            blp_pkg::ST_IDLE:
            begin
                cls_next   = '0;
                pass_next  = 1'b0;
                total_next = 36'd0;
                if (start)
                begin
                    case (blp_pkg::action_t'(action))
                        blp_pkg::ACT_DECAY: state_next = blp_pkg::ST_DECAY;
                        blp_pkg::ACT_INIT:  state_next = blp_pkg::ST_INIT;
                        default:            state_next = blp_pkg::ST_RD;
                    endcase
                end
            end
            blp_pkg::ST_DECAY:
            begin
                alpha_next = 17'(({17'd0, alpha_reg} *
                    {17'd0, (discount_reg > blp_pkg::ONE_Q16) ? blp_pkg::ONE_Q16
                                                               : discount_reg}) >> 16);
                state_next = blp_pkg::ST_IDLE;
            end
            blp_pkg::ST_INIT:
            begin
                fc_we = f_ok; fa_we = f_ok; uc_we = d_ok; ua_we = d_ok;
                fc_wd = {15'd0, init_val}; uc_wd = {15'd0, init_val};
                if (cls_ext == (CW+1)'(n_use))
                begin
                    state_next = blp_pkg::ST_IDLE;
                end
                else
                begin
                    cls_next = cls_reg + 1'b1;
                end
            end
            blp_pkg::ST_RD:
            begin
                // drop items that address nothing
                if ((act_reg == blp_pkg::ACT_LABELED &&
                        (!f_ok || {1'b0, lbl_reg} >= n_use)) ||
                    ((act_reg == blp_pkg::ACT_F2U || act_reg == blp_pkg::ACT_U2F) &&
                        (!f_ok || !d_ok)) ||
                    (act_reg == blp_pkg::ACT_NORM_F && !f_ok) ||
                    ((act_reg == blp_pkg::ACT_NORM_U || act_reg == blp_pkg::ACT_READ)
                        && !d_ok))
                begin
                    state_next = blp_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = blp_pkg::ST_RDW;
                end
            end
            blp_pkg::ST_RDW:
            begin
                case (act_reg)
                    blp_pkg::ACT_LABELED:
                    begin
                        cur_next = w_reg; acc_next = fa_rd;
                        state_next = blp_pkg::ST_MUL1;
                    end
                    blp_pkg::ACT_F2U:
                    begin
                        cur_next = fc_rd; acc_next = ua_rd;
                        state_next = blp_pkg::ST_MUL1;
                    end
                    blp_pkg::ACT_U2F:
                    begin
                        cur_next = uc_rd; acc_next = fa_rd;
                        state_next = blp_pkg::ST_MUL1;
                    end
                    blp_pkg::ACT_READ:
                    begin
                        done_next = 1'b1;
                        prob_next = uc_rd;
                        last_next = (cls_ext == (CW+1)'(n_use));
                        if (last_next)
                        begin
                            state_next = blp_pkg::ST_IDLE;
                        end
                        else
                        begin
                            cls_next = cls_reg + 1'b1;
                            state_next = blp_pkg::ST_RD;
                        end
                    end
                    default:
                    begin
                        if (!pass_reg)
                        begin
                            // fold accumulator into score, clear it
                            cur_next = blp_pkg::sat_add(is_f_side ? fc_rd : uc_rd,
                                                        {16'd0, is_f_side ? fa_rd : ua_rd});
                            fc_we = is_f_side; fa_we = is_f_side;
                            uc_we = !is_f_side; ua_we = !is_f_side;
                            fc_wd = cur_next; uc_wd = cur_next;
                            total_next = total_reg + {4'd0, cur_next};
                            if (cls_ext == (CW+1)'(n_use))
                            begin
                                cls_next = '0;
                                if (total_next == 36'd0)
                                begin
                                    state_next = blp_pkg::ST_IDLE;
                                end
                                else
                                begin
                                    pass_next  = 1'b1;
                                    state_next = blp_pkg::ST_RD;
                                end
                            end
                            else
                            begin
                                cls_next = cls_reg + 1'b1;
                                state_next = blp_pkg::ST_RD;
                            end
                        end
                        else
                        begin
                            cur_next   = div_cur;
                            state_next = blp_pkg::ST_DIVS;
                        end
                    end
                endcase
            end
            blp_pkg::ST_MUL1:
            begin
                prod_next  = 48'(({16'd0, alpha_reg} * {17'd0, cur_reg}) >> 16);
                state_next = blp_pkg::ST_MUL2;
            end
            blp_pkg::ST_MUL2:
            begin
                if (act_reg == blp_pkg::ACT_LABELED)
                begin
                    fa_wd = blp_pkg::sat_add(acc_reg, prod_reg);
                    fa_we = 1'b1;
                    state_next = blp_pkg::ST_IDLE;
                end
                else
                begin
                    // alpha is at most 1.0, so prod_reg < 2^32 and the product fits 48 bits
                    fa_wd = blp_pkg::sat_add(acc_reg,
                                             48'((65'(prod_reg[32:0]) * 65'(w_reg)) >> 16));
                    ua_wd = fa_wd;
                    fa_we = (act_reg == blp_pkg::ACT_U2F);
                    ua_we = (act_reg == blp_pkg::ACT_F2U);
                    if (cls_ext == (CW+1)'(n_use))
                    begin
                        state_next = blp_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cls_next = cls_reg + 1'b1;
                        state_next = blp_pkg::ST_RD;
                    end
                end
            end
            blp_pkg::ST_DIVS:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {cur_reg, 16'd0};
                div_req.divisor  = total_reg;
                state_next       = blp_pkg::ST_DIVW;
            end
            blp_pkg::ST_DIVW:
            begin
                if (div_rsp.done)
                begin
                    fc_we = is_f_side; uc_we = !is_f_side;
                    fc_wd = div_rsp.quotient; uc_wd = div_rsp.quotient;
                    if (cls_ext == (CW+1)'(n_use))
                    begin
                        state_next = blp_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cls_next = cls_reg + 1'b1;
                        state_next = blp_pkg::ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = blp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= blp_pkg::ST_IDLE;
            alpha_reg       <= blp_pkg::ONE_Q16;
            class_count_reg <= 4'd2;
            discount_reg    <= 17'd32768;
            done            <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            alpha_reg <= alpha_next;
            done      <= done_next;
            if (cfg_we && cfg_index == blp_pkg::CFG_CLASS_COUNT)
            begin
                class_count_reg <= cfg_data[3:0];
            end
            if (cfg_we && cfg_index == blp_pkg::CFG_DISCOUNT)
            begin
                discount_reg <= cfg_data;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        cls_reg     <= cls_next;
        pass_reg    <= pass_next;
        total_reg   <= total_next;
        cur_reg     <= cur_next;
        acc_reg     <= acc_next;
        prod_reg    <= prod_next;
        probability <= prob_next;
        last        <= last_next;
        cls_out_reg <= cls_out_next;
        if (state_reg == blp_pkg::ST_IDLE && start)
        begin
            act_reg <= blp_pkg::action_t'(action);
            f_reg   <= feature_index;
            d_reg   <= data_index;
            lbl_reg <= class_label;
            w_reg   <= weight;
        end
    end

    assign busy        = (state_reg != blp_pkg::ST_IDLE);
    assign node_index  = d_reg;
    assign class_index = 3'(cls_out_reg);

    blp_ram #(.WIDTH(32), .DEPTH(blp_pkg::FEATURE_NODES * blp_pkg::MAX_CLASSES)) u_fc (
        .clk(clk), .we(fc_we), .addr(f_addr), .wdata(fc_wd), .rdata(fc_rd));
    blp_ram #(.WIDTH(32), .DEPTH(blp_pkg::FEATURE_NODES * blp_pkg::MAX_CLASSES)) u_fa (
        .clk(clk), .we(fa_we), .addr(f_addr), .wdata(fa_wd), .rdata(fa_rd));
    blp_ram #(.WIDTH(32), .DEPTH(blp_pkg::UNLABELED_NODES * blp_pkg::MAX_CLASSES)) u_uc (
        .clk(clk), .we(uc_we), .addr(u_addr), .wdata(uc_wd), .rdata(uc_rd));
    blp_ram #(.WIDTH(32), .DEPTH(blp_pkg::UNLABELED_NODES * blp_pkg::MAX_CLASSES)) u_ua (
        .clk(clk), .we(ua_we), .addr(u_addr), .wdata(ua_wd), .rdata(ua_rd));

    blp_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

    `BLP_ASSERT(a_done_busy, clk, rst_n, done |-> $past(busy))
    `BLP_ASSERT(a_alpha_hold, clk, rst_n, (state_reg != blp_pkg::ST_DECAY) |=> $stable(alpha_reg))
    `BLP_ASSERT(a_last_done, clk, rst_n, last && done |-> !busy)
    `BLP_ASSERT_NEVER(a_div_idle, clk, rst_n, div_req.start && state_reg == blp_pkg::ST_IDLE)
endmodule
